// ===== rtl/sdepq_pkg.sv =====
// Package for the sorted double-ended priority queue.
// Holds command and status codes, the cell control struct and data constants.
// No dependencies.
`default_nettype none

package sdepq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    localparam logic [1:0] CMD_INSERT     = 2'd0;
    localparam logic [1:0] CMD_REMOVE_MIN = 2'd1;
    localparam logic [1:0] CMD_REMOVE_MAX = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic signed [DATA_W-1:0] t_data;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic ins;  // insert the new value at its sorted place
        logic shl;  // shift every entry one cell toward the head
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/sorted_double_ended_priority_queue_top.sv =====
// Sorted double-ended priority queue: a chain of sdepq_cell entries plus count and output logic.
// Depends on sdepq_pkg and sdepq_cell.
// Results are registered: each accepted transaction's result is registered in the cycle after it is accepted.
// Throughput: one transaction per cycle while the output is not stalled; all cells compare and shift in parallel.
// Reset: synchronous active-low i_rst_n clears the entry count and the output valid;
// cell contents are not reset and are never read before being written.
`default_nettype none

module sorted_double_ended_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // [31:0] value
    input  wire  [1:0]  i_s_axis_tuser,   // [1:0] cmd
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] result_value, [36:32] occupancy, rest zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import sdepq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_ovalid;
    t_data         r_res;
    t_data         n_res;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic [OCC_W-1:0] r_occ;

    logic          w_accept;
    logic [1:0]    w_cmd;
    t_data         w_val;
    logic          w_full;
    logic          w_empty;
    t_cell_ctl     w_ctl;
    logic [IW-1:0] w_last_idx;

    t_data w_cell_val [CAPACITY];
    logic  w_place    [CAPACITY];
    logic  w_valid    [CAPACITY];

    assign o_s_axis_tready = !r_ovalid || i_m_axis_tready;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd    = i_s_axis_tuser;
    assign w_val    = $signed(i_s_axis_tdata);
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_last_idx = IW'(r_count - CW'(1));

    assign w_ctl.ins = w_accept && (w_cmd == CMD_INSERT) && !w_full;
    assign w_ctl.shl = w_accept && (w_cmd == CMD_REMOVE_MIN) && !w_empty;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_data w_left;
            logic  w_left_place;
            t_data w_right;

            assign w_valid[g] = (CW'(g) < r_count);

            if (g == 0) begin : g_head
                assign w_left       = '0;
                assign w_left_place = 1'b0;
            end else begin : g_body
                assign w_left       = w_cell_val[g-1];
                assign w_left_place = w_place[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = w_cell_val[g];
            end else begin : g_mid
                assign w_right = w_cell_val[g+1];
            end

            sdepq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_new_value   (w_val),
                .i_valid       (w_valid[g]),
                .i_left_value  (w_left),
                .i_left_place  (w_left_place),
                .i_right_value (w_right),
                .o_value       (w_cell_val[g]),
                .o_place       (w_place[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_res    = '0;
        n_status = ST_OK;
        case (w_cmd)
            CMD_INSERT: begin
                if (w_full) begin
                    n_res    = INT_MIN;
                    n_status = ST_FULL;
                end else begin
                    n_res   = w_val;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_REMOVE_MIN: begin
                if (w_empty) begin
                    n_res    = INT_MIN;
                    n_status = ST_EMPTY;
                end else begin
                    n_res   = w_cell_val[0];
                    n_count = r_count - CW'(1);
                end
            end
            CMD_REMOVE_MAX: begin
                if (w_empty) begin
                    n_res    = INT_MIN;
                    n_status = ST_EMPTY;
                end else begin
                    n_res   = w_cell_val[w_last_idx];
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_res    = '0;
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res    <= n_res;
            r_status <= n_status;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {3'b000, r_occ, r_res};
    assign o_m_axis_tuser  = r_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the count");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(2) |-> w_cell_val[0] <= w_cell_val[1])
        else $error("head cells out of order");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_status == ST_EMPTY) |-> (r_occ == '0 && r_res == INT_MIN))
        else $error("empty result inconsistent");
`endif

endmodule

`default_nettype wire

// ===== rtl/sdepq_cell.sv =====
// One storage cell of the sorted chain.
// Depends on sdepq_pkg; neighbors exchange value and placement flag.
`default_nettype none

module sdepq_cell (
    input  wire                    i_clk,
    input  sdepq_pkg::t_cell_ctl   i_ctl,
    input  sdepq_pkg::t_data       i_new_value,
    input  wire                    i_valid,
    input  sdepq_pkg::t_data       i_left_value,
    input  wire                    i_left_place,
    input  sdepq_pkg::t_data       i_right_value,
    output sdepq_pkg::t_data       o_value,
    output logic                   o_place
);
    import sdepq_pkg::*;

    t_data r_value;
    t_data n_value;

    // Empty cells count as greater-or-equal so the value lands at the tail
    assign o_place = !i_valid || (r_value >= i_new_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins && o_place) begin
            n_value = i_left_place ? i_left_value : i_new_value;
        end else if (i_ctl.shl) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire
